### design/assert_macros.svh
// Assertion macros shared by the shape function evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define QSF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("qsf assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define QSF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("qsf forbidden condition seen");

`endif

### design/qsf_pkg.sv
// Types, node tables and fixed-point helpers of the quadrilateral shape function evaluator.
package qsf_pkg;

  localparam int IN_FRAC = 14;

  localparam logic [2:0] LAST_IDX_BIL = 3'd3;
  localparam logic [2:0] LAST_IDX_SER = 3'd7;

  typedef enum logic [1:0] {
    ELEM_BILINEAR          = 2'd0,
    ELEM_SER_INTERLEAVED   = 2'd1,
    ELEM_SER_CORNERS_FIRST = 2'd2,
    ELEM_BILINEAR_ALT      = 2'd3
  } elem_kind_e;

  typedef enum logic [1:0] {
    NODE_BIL,
    NODE_CORNER,
    NODE_MID_XI,
    NODE_MID_ETA
  } node_kind_e;

  typedef logic signed [1:0] sign_t;

  typedef struct packed {
    node_kind_e kind;
    sign_t      sx;
    sign_t      se;
    logic [2:0] index;
    logic       last;
  } node_t;

  // Node sign pairs in interleaved order: corner, midside, corner, ...
  localparam sign_t NODE_SX [8] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1};
  localparam sign_t NODE_SE [8] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0};

  localparam logic signed [63:0] OUT_MAX = 64'sd65535;
  localparam logic signed [63:0] OUT_MIN = -64'sd65536;

  function automatic node_t node_decode(input elem_kind_e elem, input logic [2:0] k);
    node_t      nd;
    logic [2:0] j;
    nd       = '0;
    nd.index = k;
    unique case (elem)
      ELEM_SER_INTERLEAVED: begin
        j       = k;
        nd.last = (k == LAST_IDX_SER);
      end
      ELEM_SER_CORNERS_FIRST: begin
        j       = {k[1:0], k[2]};
        nd.last = (k == LAST_IDX_SER);
      end
      ELEM_BILINEAR, ELEM_BILINEAR_ALT: begin
        j       = {k[1:0], 1'b0};
        nd.last = (k == LAST_IDX_BIL);
      end
    endcase
    nd.sx = NODE_SX[j];
    nd.se = NODE_SE[j];
    priority if (elem == ELEM_BILINEAR || elem == ELEM_BILINEAR_ALT) begin
      nd.kind = NODE_BIL;
    end else if (!j[0]) begin
      nd.kind = NODE_CORNER;
    end else if (nd.sx == 2'sd0) begin
      nd.kind = NODE_MID_XI;
    end else begin
      nd.kind = NODE_MID_ETA;
    end
    return nd;
  endfunction

  function automatic logic signed [16:0] sgn_apply(input sign_t s, input logic signed [15:0] v);
    logic signed [16:0] r;
    priority if (s == 2'sd0) begin
      r = '0;
    end else if (s[1]) begin
      r = -17'(v);
    end else begin
      r = 17'(v);
    end
    return r;
  endfunction

  // Scales by 2^-sh with floor, then saturates to the 17-bit result range.
  function automatic logic signed [16:0] to_out(input logic signed [63:0] num, input int sh);
    logic signed [63:0] t;
    if (sh >= 0) begin
      t = num >>> sh;
    end else begin
      t = num <<< (-sh);
    end
    if (t > OUT_MAX) begin
      t = OUT_MAX;
    end else if (t < OUT_MIN) begin
      t = OUT_MIN;
    end
    return t[16:0];
  endfunction

endpackage

### design/quad_shape_function_eval.sv
// Quadrilateral shape functions and derivatives, one node result per unstalled cycle.
//
//   channel   dir  handshake                        payload
//   s_axis    in   s_axis_tvalid / s_axis_tready    tdata: xi_coord, eta_coord
//   m_axis    out  m_axis_tvalid / m_axis_tready    tdata: node fields, tlast: last_node
//   cfg       in   cfg_valid_i / cfg_ready_o        cfg_data_i: element_kind
//
// A point yields four node results for the bilinear element and eight for the
// serendipity elements: the node sequencer issues one node per cycle, while stage 1
// can advance, into a four-stage pipeline: stages 1 to 3 and the output register.
// The next point is accepted in the cycle the current point issues its last node.
// Reset clears the sequencer, the pipeline valid bits and element_kind.
// A low m_axis_tready holds a full stage only if every later stage is full; gaps fill.
`include "assert_macros.svh"

module quad_shape_function_eval #(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // xi_coord[15:0], eta_coord[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // node_index[2:0], shape_value[19:3],
                                     // deriv_xi[36:20], deriv_eta[53:37], zeros
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  localparam int InF = qsf_pkg::IN_FRAC;
  localparam int ShNBil   = 2 * InF + 2 - FRAC_BITS;
  localparam int ShDBil   = InF + 2 - FRAC_BITS;
  localparam int ShNCor   = 3 * InF + 2 - FRAC_BITS;
  localparam int ShDCor   = 2 * InF + 2 - FRAC_BITS;
  localparam int ShNMid   = 3 * InF + 1 - FRAC_BITS;
  localparam int ShDMidLn = 2 * InF - FRAC_BITS;
  localparam int ShDMidSq = 2 * InF + 1 - FRAC_BITS;

  localparam logic signed [17:0] One18 = 18'sd1 <<< InF;
  localparam logic signed [31:0] OneSq = 32'sd1 <<< (2 * InF);

  // Configuration.
  qsf_pkg::elem_kind_e kind_q;
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  logic               busy_q, busy_d;
  logic [2:0]         cnt_q, cnt_d;
  logic signed [15:0] x_q, e_q;
  qsf_pkg::node_t     node_c;
  logic               accept, issue;
  logic               en1, en2, en3, en_o;

  // Stage 1.
  logic                v1_q;
  qsf_pkg::node_t      nd1_q;
  logic signed [15:0]  x1_q, e1_q;
  logic signed [16:0]  p1_q, q1_q, p1_d, q1_d;
  logic signed [17:0]  r1_q, ta1_q, tb1_q, r1_d, ta1_d, tb1_d;
  logic [30:0]         sq1_q;
  logic signed [16:0]  xs_c, es_c;
  logic signed [15:0]  sqm_c;
  logic signed [31:0]  sq_full_c;

  // Stage 2.
  logic                v2_q;
  qsf_pkg::node_t      nd2_q;
  logic signed [16:0]  p2_q, q2_q;
  logic signed [17:0]  r2_q;
  logic signed [30:0]  w2_q, w2_d;
  logic signed [33:0]  pq2_q, pq2_d;
  logic signed [34:0]  qta2_q, ptb2_q, qta2_d, ptb2_d;
  logic signed [32:0]  xq2_q, ep2_q, xq2_d, ep2_d;

  // Stage 3.
  logic                v3_q;
  qsf_pkg::node_t      nd3_q;
  logic signed [51:0]  n3_q, n3_d;
  logic signed [35:0]  dx3_q, de3_q, dx3_d, de3_d;
  logic signed [33:0]  ma_c;
  logic signed [17:0]  mb_c;
  logic signed [51:0]  prod_c;

  // Output register.
  logic                vo_q;
  logic [2:0]          idx_o_q;
  logic signed [16:0]  shp_o_q, dxi_o_q, deta_o_q, shp_d, dxi_d, deta_d;
  logic                last_o_q;
  logic                last_idx_ok;

  always_comb begin
    en_o   = !vo_q || m_axis_tready;
    en3    = !v3_q || en_o;
    en2    = !v2_q || en3;
    en1    = !v1_q || en2;
    node_c = qsf_pkg::node_decode(kind_q, cnt_q);
    issue  = busy_q && en1;
    s_axis_tready = !busy_q || (en1 && node_c.last);
    accept = s_axis_tvalid && s_axis_tready;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    priority if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (issue && node_c.last) begin
      busy_d = 1'b0;
      cnt_d  = '0;
    end else if (issue) begin
      cnt_d = cnt_q + 3'd1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= qsf_pkg::ELEM_BILINEAR;
      busy_q <= 1'b0;
      cnt_q  <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vo_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        kind_q <= qsf_pkg::elem_kind_e'(cfg_data_i);
      end
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (en1) begin
        v1_q <= issue;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en_o) begin
        vo_q <= v3_q;
      end
    end
  end

  // Stage 1: linear factors and the square of the varying coordinate.
  always_comb begin
    xs_c      = qsf_pkg::sgn_apply(node_c.sx, x_q);
    es_c      = qsf_pkg::sgn_apply(node_c.se, e_q);
    p1_d      = 17'(One18 + 18'(xs_c));
    q1_d      = 17'(One18 + 18'(es_c));
    r1_d      = 18'(18'(xs_c) + 18'(es_c) - One18);
    ta1_d     = 18'((19'(xs_c) <<< 1) + 19'(es_c));
    tb1_d     = 18'(19'(xs_c) + (19'(es_c) <<< 1));
    sqm_c     = (node_c.sx == 2'sd0) ? x_q : e_q;
    sq_full_c = 32'(sqm_c) * 32'(sqm_c);
  end

  // Stage 2: first products.
  always_comb begin
    w2_d   = 31'(OneSq - $signed({1'b0, sq1_q}));
    pq2_d  = 34'(p1_q) * 34'(q1_q);
    qta2_d = 35'(q1_q) * 35'(ta1_q);
    ptb2_d = 35'(p1_q) * 35'(tb1_q);
    xq2_d  = 33'(x1_q) * 33'(q1_q);
    ep2_d  = 33'(e1_q) * 33'(p1_q);
  end

  // Stage 3: final product of the value and sign of the derivatives.
  always_comb begin
    ma_c   = (nd2_q.kind == qsf_pkg::NODE_CORNER) ? pq2_q : 34'(w2_q);
    mb_c   = (nd2_q.kind == qsf_pkg::NODE_CORNER) ? r2_q :
             (nd2_q.kind == qsf_pkg::NODE_MID_XI) ? 18'(q2_q) : 18'(p2_q);
    prod_c = 52'(ma_c) * 52'(mb_c);
    n3_d   = (nd2_q.kind == qsf_pkg::NODE_BIL) ? 52'(pq2_q) : prod_c;
    unique case (nd2_q.kind)
      qsf_pkg::NODE_BIL: begin
        dx3_d = nd2_q.sx[1] ? -36'(q2_q) : 36'(q2_q);
        de3_d = nd2_q.se[1] ? -36'(p2_q) : 36'(p2_q);
      end
      qsf_pkg::NODE_CORNER: begin
        dx3_d = nd2_q.sx[1] ? -36'(qta2_q) : 36'(qta2_q);
        de3_d = nd2_q.se[1] ? -36'(ptb2_q) : 36'(ptb2_q);
      end
      qsf_pkg::NODE_MID_XI: begin
        dx3_d = -36'(xq2_q);
        de3_d = nd2_q.se[1] ? -36'(w2_q) : 36'(w2_q);
      end
      qsf_pkg::NODE_MID_ETA: begin
        dx3_d = nd2_q.sx[1] ? -36'(w2_q) : 36'(w2_q);
        de3_d = -36'(ep2_q);
      end
    endcase
  end

  // Output stage: scale to the output fraction, floor and saturate.
  always_comb begin
    unique case (nd3_q.kind)
      qsf_pkg::NODE_BIL: begin
        shp_d  = qsf_pkg::to_out(64'(n3_q), ShNBil);
        dxi_d  = qsf_pkg::to_out(64'(dx3_q), ShDBil);
        deta_d = qsf_pkg::to_out(64'(de3_q), ShDBil);
      end
      qsf_pkg::NODE_CORNER: begin
        shp_d  = qsf_pkg::to_out(64'(n3_q), ShNCor);
        dxi_d  = qsf_pkg::to_out(64'(dx3_q), ShDCor);
        deta_d = qsf_pkg::to_out(64'(de3_q), ShDCor);
      end
      qsf_pkg::NODE_MID_XI: begin
        shp_d  = qsf_pkg::to_out(64'(n3_q), ShNMid);
        dxi_d  = qsf_pkg::to_out(64'(dx3_q), ShDMidLn);
        deta_d = qsf_pkg::to_out(64'(de3_q), ShDMidSq);
      end
      qsf_pkg::NODE_MID_ETA: begin
        shp_d  = qsf_pkg::to_out(64'(n3_q), ShNMid);
        dxi_d  = qsf_pkg::to_out(64'(dx3_q), ShDMidSq);
        deta_d = qsf_pkg::to_out(64'(de3_q), ShDMidLn);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= $signed(s_axis_tdata[15:0]);
      e_q <= $signed(s_axis_tdata[31:16]);
    end
    if (en1) begin
      nd1_q <= node_c;
      x1_q  <= x_q;
      e1_q  <= e_q;
      p1_q  <= p1_d;
      q1_q  <= q1_d;
      r1_q  <= r1_d;
      ta1_q <= ta1_d;
      tb1_q <= tb1_d;
      sq1_q <= sq_full_c[30:0];
    end
    if (en2) begin
      nd2_q  <= nd1_q;
      p2_q   <= p1_q;
      q2_q   <= q1_q;
      r2_q   <= r1_q;
      w2_q   <= w2_d;
      pq2_q  <= pq2_d;
      qta2_q <= qta2_d;
      ptb2_q <= ptb2_d;
      xq2_q  <= xq2_d;
      ep2_q  <= ep2_d;
    end
    if (en3) begin
      nd3_q <= nd2_q;
      n3_q  <= n3_d;
      dx3_q <= dx3_d;
      de3_q <= de3_d;
    end
    if (en_o) begin
      idx_o_q  <= nd3_q.index;
      last_o_q <= nd3_q.last;
      shp_o_q  <= shp_d;
      dxi_o_q  <= dxi_d;
      deta_o_q <= deta_d;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tlast  = last_o_q;
  assign m_axis_tdata  = {2'b00, deta_o_q, dxi_o_q, shp_o_q, idx_o_q};

  assign last_idx_ok = (idx_o_q == qsf_pkg::LAST_IDX_BIL) ||
                       (idx_o_q == qsf_pkg::LAST_IDX_SER);

  `QSF_ASSERT(a_accept_starts_point, clk_i, rst_ni, accept |=> busy_q)
  `QSF_ASSERT(a_stage3_holds, clk_i, rst_ni, v3_q && !en3 |=> v3_q && $stable(n3_q))
  `QSF_ASSERT_NEVER(a_last_index, clk_i, rst_ni, vo_q && last_o_q && !last_idx_ok)

endmodule
